// ===== src/imd_pkg.sv =====
// shared types and constants for the integer matrix determinant core
// no dependencies
package imd_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int SIZE_W        = 4;
    localparam int ELEM_W        = 32;
    localparam int DET_W         = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;   // store accepted element, advance load position
        logic t_start;   // clear accumulator and column index
        logic j_inc;     // next column
        logic rd;        // read element and sub-minor
        logic mul_lo;    // low partial product
        logic mul_hi;    // high partial product
        logic acc;       // add or subtract term
        logic t_write;   // write minor, advance subset
        logic det_init;  // first subset
        logic out_load;  // move determinant into output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic load_last;
        logic j_in_mask;
        logic j_last;
        logic mask_full;
        logic out_free;
    } t_status;

endpackage

// ===== src/integer_matrix_determinant_core.sv =====
// integer matrix determinant: loads n*n elements, then expands minors over subsets
// after loading, for each of the 2^n - 1 column subsets it accumulates one term per
// column in the subset through the split multiplier, reading sub-minors from the
// minor table memory, then moves the determinant into the output register
// throughput: one matrix at a time, loading resumes once the result register frees
// synchronous active-low reset restores order 4 and clears load position
module integer_matrix_determinant_core #(
    parameter int MAX_ORDER = imd_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [imd_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [imd_pkg::ELEM_W-1:0] i_element,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [imd_pkg::DET_W-1:0]  o_determinant
);
    import imd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    loading;

    assign o_stall = !loading;

    // sequencer
    imd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_int (o_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_loading   (loading)
    );

    // datapath
    imd_dpath #(.MAX_ORDER(MAX_ORDER)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_element     (i_element),
        .i_out_stall   (i_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_determinant (o_determinant)
    );

    // a new result appears just as loading resumes
    a_result_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result without return to load");
    a_outload_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_valid)
        else $error("result transfer lost");
    a_outload_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> o_stall)
        else $error("result loaded during load phase");

endmodule

// ===== src/imd_ctrl.sv =====
// sequencer for load, minor-table expansion and result hand-off
// depends on imd_pkg
module imd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall_int,
    input  imd_pkg::t_status i_status,
    output imd_pkg::t_cmd    o_cmd,
    output logic             o_loading
);
    import imd_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_TSTART, S_JCHK, S_MLO, S_MHI, S_ACC, S_WRITE, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    cmd.load_wr = 1'b1;
                    if (i_status.load_last) begin
                        cmd.det_init = 1'b1;
                        n_state      = S_TSTART;
                    end
                end
            end
            S_TSTART: begin
                cmd.t_start = 1'b1;
                n_state     = S_JCHK;
            end
            S_JCHK: begin
                if (i_status.j_in_mask) begin
                    cmd.rd  = 1'b1;
                    n_state = S_MLO;
                end else if (i_status.j_last) begin
                    n_state = S_WRITE;
                end else begin
                    cmd.j_inc = 1'b1;
                end
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                n_state    = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_WRITE;
                end else begin
                    cmd.j_inc = 1'b1;
                    n_state   = S_JCHK;
                end
            end
            S_WRITE: begin
                if (i_status.mask_full) begin
                    n_state = S_DONE;
                end else begin
                    cmd.t_write = 1'b1;
                    n_state     = S_TSTART;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd     = cmd;
    assign o_loading = (r_state == S_LOAD);

    // multiply steps follow a read in order
    a_mlo_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MLO) |-> $past(cmd.rd))
        else $error("multiply without read");
    a_acc_after_mhi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> $past(r_state == S_MHI))
        else $error("accumulate out of order");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_wr) |-> (r_state == S_LOAD) && !i_stall_int)
        else $error("load while busy");

endmodule

// ===== src/imd_dpath.sv =====
// datapath: element store, minor table memory, split multiplier, accumulator
// depends on imd_pkg
module imd_dpath #(
    parameter int MAX_ORDER = imd_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [imd_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic signed [imd_pkg::ELEM_W-1:0] i_element,
    input  logic                              i_out_stall,
    input  imd_pkg::t_cmd                     i_cmd,
    output imd_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic signed [imd_pkg::DET_W-1:0]  o_determinant
);
    import imd_pkg::*;

    localparam int IW    = $clog2(MAX_ORDER);
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int AW    = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int DEPTH = 1 << MAX_ORDER;

    logic [SIZE_W-1:0]    r_size;
    logic [IW-1:0]        r_row, r_col, r_j;
    logic [MAX_ORDER-1:0] r_mask;
    logic [DET_W-1:0]     r_acc, r_sub, r_plo, r_out;
    logic [ELEM_W-1:0]    r_elem, r_phi;
    logic                 r_sub_one, r_neg, r_out_valid;
    logic [ELEM_W-1:0]    mat_mem [MAX_ORDER*MAX_ORDER];
    logic [DET_W-1:0]     minor_mem [DEPTH];

    logic [OW-1:0]        n_ord;
    logic [MAX_ORDER-1:0] full, rd_mask;
    logic [OW-1:0]        pop;
    logic [IW-1:0]        t_row;
    logic                 par;
    logic [DET_W:0]       lo_prod;
    logic [DET_W-1:0]     term;
    logic                 out_free;

    // effective order
    always_comb begin
        if (r_size == '0) begin
            n_ord = OW'(1);
        end else if (int'(r_size) > MAX_ORDER) begin
            n_ord = OW'(MAX_ORDER);
        end else begin
            n_ord = OW'(r_size);
        end
    end

    // full subset, row of current subset, sign parity
    always_comb begin
        pop = '0;
        par = 1'b0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            full[i] = (i < int'(n_ord));
            pop     = pop + OW'(r_mask[i]);
            if (i > int'(r_j)) par = par ^ r_mask[i];
        end
        t_row   = IW'(pop - OW'(1));
        rd_mask = r_mask ^ (MAX_ORDER'(1) << r_j);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.load_last = (int'(r_row) == int'(n_ord) - 1) &&
                                (int'(r_col) == int'(n_ord) - 1);
    assign o_status.j_in_mask = r_mask[r_j];
    assign o_status.j_last    = (int'(r_j) == int'(n_ord) - 1);
    assign o_status.mask_full = (r_mask == full);
    assign o_status.out_free  = out_free;

    // 33x32 signed low product and 32x32 high product, mod 2^64
    assign lo_prod = $signed({1'b0, r_sub[31:0]}) * $signed(r_elem);
    assign term    = r_plo + {r_phi, 32'b0};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
                r_row  <= '0;
                r_col  <= '0;
            end else if (i_cmd.load_wr) begin
                if (int'(r_col) == int'(n_ord) - 1) begin
                    r_col <= '0;
                    r_row <= (int'(r_row) == int'(n_ord) - 1) ? '0 : r_row + IW'(1);
                end else begin
                    r_col <= r_col + IW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // expansion datapath and memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mat_mem[AW'(int'(r_row) * MAX_ORDER + int'(r_col))] <= i_element;
        end
        if (i_cmd.det_init) r_mask <= MAX_ORDER'(1);
        if (i_cmd.t_write) begin
            minor_mem[r_mask] <= r_acc;
            r_mask            <= r_mask + MAX_ORDER'(1);
        end
        if (i_cmd.t_start) begin
            r_acc <= '0;
            r_j   <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IW'(1);
        end
        if (i_cmd.rd) begin
            r_elem    <= mat_mem[AW'(int'(t_row) * MAX_ORDER + int'(r_j))];
            r_sub     <= minor_mem[rd_mask];
            r_sub_one <= (rd_mask == '0);
            r_neg     <= par;
        end
        if (i_cmd.mul_lo) begin
            if (r_sub_one) begin
                r_sub <= DET_W'(1);
                r_plo <= {{32{r_elem[31]}}, r_elem};
            end else begin
                r_plo <= lo_prod[DET_W-1:0];
            end
        end
        if (i_cmd.mul_hi) r_phi <= ELEM_W'(r_sub[63:32] * r_elem);
        if (i_cmd.acc)    r_acc <= r_neg ? r_acc - term : r_acc + term;
        if (i_cmd.out_load) r_out <= r_acc;
    end

    assign o_valid       = r_out_valid;
    assign o_determinant = r_out;

endmodule
